[rtl/double_ended_queue_assert.svh]
// Assertion macros shared by the checker.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define DEQ_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("deque assertion failed");

// next-cycle implication
`define DEQ_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("deque assertion failed");

`endif

[rtl/deq_pkg.sv]
package deq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FN_POP_FRONT  = 3'd2;
   localparam logic [2:0] FN_POP_BACK   = 3'd3;
   localparam logic [2:0] FN_SHOW       = 3'd4;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
   localparam logic [1:0] ST_SHOW_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL       = 2'd3;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] item;
      logic                     last;
   } rsp_type;

   function automatic idx_type idx_inc(input idx_type a);
      return (a == IDX_W'(DEPTH - 1)) ? '0 : idx_type'(a + 1'b1);
   endfunction

   function automatic idx_type idx_dec(input idx_type a);
      return (a == '0) ? IDX_W'(DEPTH - 1) : idx_type'(a - 1'b1);
   endfunction

   // a and b both below DEPTH, so one conditional subtract wraps the sum
   function automatic idx_type idx_add(input idx_type a, input idx_type b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (IDX_W + 1)'(DEPTH)) begin
         sum = sum - (IDX_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

[rtl/deq_ram.sv]
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [WIDTH-1:0]               wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit values held in a ring RAM of
// DEPTH entries, tracked by a front index and an entry count. Push front,
// push back, pop front and pop back each return one status response; a push
// on a full queue is dropped with status full, a pop on an empty queue
// returns status pop-empty. Display streams every entry from front to back,
// one response per cycle while rsp_ready is high, with rsp_last on the back
// entry; entries are read one at a time through the single registered RAM
// read port, and no new request is taken until the last entry is loaded.
// Func codes 5 to 7 are consumed with no response. The response register
// lets a new request be taken in the cycle the previous response is taken.
module double_ended_queue import deq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_func,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_item,
   output logic                     rsp_last
);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_WALK = 1'b1;

   logic    state_ff, state_in;
   idx_type front_ff, front_in;
   cnt_type count_ff, count_in;
   idx_type rd_pos_ff, rd_pos_in;
   idx_type left_ff, left_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                accept;
   logic                out_free;
   logic                load;
   logic                full;
   logic                empty;
   logic                wr_en;
   idx_type             wr_addr;
   logic                rd_en;
   idx_type             rd_addr;
   logic [DATA_W-1:0]   rd_data;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == STATE_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      state_in  = state_ff;
      front_in  = front_ff;
      count_in  = count_ff;
      rd_pos_in = rd_pos_ff;
      left_in   = left_ff;
      load      = 1'b0;
      rsp_in    = '{status: ST_OK, item: '0, last: 1'b1};
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      rd_en     = 1'b0;
      rd_addr   = front_ff;

      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FN_PUSH_FRONT, FN_PUSH_BACK: begin
                     load = 1'b1;
                     if (full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = cnt_type'(count_ff + 1'b1);
                        if (req_func == FN_PUSH_FRONT) begin
                           front_in = idx_dec(front_ff);
                           wr_addr  = idx_dec(front_ff);
                        end else begin
                           wr_addr = idx_add(front_ff, count_ff[IDX_W-1:0]);
                        end
                     end
                  end
                  FN_POP_FRONT, FN_POP_BACK: begin
                     load = 1'b1;
                     if (empty) begin
                        rsp_in.status = ST_POP_EMPTY;
                     end else begin
                        count_in = cnt_type'(count_ff - 1'b1);
                        if (req_func == FN_POP_FRONT) begin
                           front_in = idx_inc(front_ff);
                        end
                     end
                  end
                  FN_SHOW: begin
                     if (empty) begin
                        load          = 1'b1;
                        rsp_in.status = ST_SHOW_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = front_ff;
                        rd_pos_in = idx_inc(front_ff);
                        left_in   = idx_type'(count_ff - 1'b1);
                        state_in  = STATE_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         STATE_WALK: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_in.item = rd_data;
               rsp_in.last = (left_ff == '0);
               if (left_ff != '0) begin
                  rd_en     = 1'b1;
                  rd_addr   = rd_pos_ff;
                  rd_pos_in = idx_inc(rd_pos_ff);
                  left_in   = idx_type'(left_ff - 1'b1);
               end else begin
                  state_in = STATE_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff <= rd_pos_in;
      left_ff   <= left_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   deq_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_item   = rsp_ff.item;
   assign rsp_last   = rsp_ff.last;

endmodule

[rtl/deq_checker.sv]
`include "double_ended_queue_assert.svh"

module deq_checker import deq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [1:0]               rsp_status,
   input logic signed [DATA_W-1:0] rsp_item,
   input logic                     rsp_last
);

   // response holds while stalled
   `DEQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))

   // error and empty statuses carry no item and end the request
   `DEQ_ASSERT_IMP(a_status_item, clock, reset, rsp_valid && (rsp_status != ST_OK), (rsp_item == '0) && rsp_last)

   // no new request while a display is still streaming
   `DEQ_ASSERT_IMP(a_walk_blocks, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // nothing pending right after reset
   `DEQ_ASSERT_IMP(a_reset_idle, clock, reset, $past(reset), !rsp_valid)

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
